FILE: rtl/core/mat_pkg.sv
package mat_pkg;

	localparam int SLOT_COUNT = 5;
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

	localparam logic [3:0] PKT_CONNACK = 4'h2;
	localparam logic [3:0] PKT_PUBLISH = 4'h3;
	localparam logic [3:0] PKT_PUBACK  = 4'h4;
	localparam logic [3:0] PKT_SUBACK  = 4'h9;

	typedef enum logic [2:0] {
		CMD_PUBLISH   = 3'd0,
		CMD_SUBSCRIBE = 3'd1,
		CMD_INCOMING  = 3'd2,
		CMD_MAINTAIN  = 3'd3,
		CMD_RESET     = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		EV_ID_ASSIGNED = 3'd0,
		EV_CONNECTED   = 3'd1,
		EV_ACKED       = 3'd2,
		EV_SUBACK      = 3'd3,
		EV_DATA        = 3'd4,
		EV_TIMEOUT     = 3'd5,
		EV_DISCONNECT  = 3'd6
	} event_t;

	typedef struct packed {
		logic   ld_in;
		logic   take_id;
		logic   set_conn;
		logic   clr_table;
		logic   ld_res;
		event_t res_ev;
		logic   idx_clr;
		logic   idx_inc;
		logic   clr_hit;
		logic   wr_slot;
		logic   free_slot;
		logic   mark_hit;
		logic   ld_out;
		logic   out_sweep;
	} mat_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       qos_nz;
		logic       send_ok;
		logic       plen_zero;
		logic [3:0] pkt_type;
		logic       free_hit;
		logic       match_hit;
		logic       expire_hit;
		logic       sweep_hit;
		logic       idx_last;
		logic       out_free;
	} mat_sts_t;

endpackage

FILE: rtl/core/mat_dp.sv
module mat_dp
	import mat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  mat_cmd_t    cmd,
	output mat_sts_t    sts,
	input  logic        cfg_valid,
	input  logic [31:0] cfg_data,
	input  logic [2:0]  command,
	input  logic [1:0]  qos,
	input  logic        send_ok,
	input  logic [31:0] now_ticks,
	input  logic [7:0]  header_byte,
	input  logic [7:0]  remaining_length,
	input  logic [15:0] id_or_topic_len,
	input  logic [15:0] packet_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [15:0] msg_id,
	output logic [15:0] topic_length,
	output logic [7:0]  payload_length,
	output logic        length_error,
	output logic        tracked,
	output logic        is_connected,
	output logic        last
);

	logic [2:0]  cmd_q;
	logic [1:0]  qos_q;
	logic        send_ok_q;
	logic [31:0] now_q;
	logic [7:0]  hdr_q;
	logic [7:0]  rem_q;
	logic [15:0] idt_q;
	logic [15:0] plen_q;

	logic [31:0] timeout_q;
	logic [15:0] next_id_q;
	logic        conn_q;

	logic [15:0]           slot_id_q [SLOT_COUNT];
	logic [31:0]           slot_ts_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] slot_valid_q;
	logic [SLOT_COUNT-1:0] hit_q;
	logic [IDX_W-1:0]      idx_q;

	event_t      res_ev_q;
	logic [15:0] res_id_q;
	logic [15:0] res_tlen_q;
	logic [7:0]  res_plen_q;
	logic        res_err_q;
	logic        res_trk_q;

	logic        out_valid_q;
	event_t      out_ev_q;
	logic [15:0] out_id_q;
	logic [15:0] out_tlen_q;
	logic [7:0]  out_plen_q;
	logic        out_err_q;
	logic        out_trk_q;
	logic        out_conn_q;
	logic        out_last_q;

	logic [15:0] id_inc;
	logic [17:0] diff;
	logic [31:0] age;
	logic        sweep_last;

	assign id_inc = next_id_q + 16'd1;
	assign diff   = {10'd0, rem_q} - 18'd2 - {2'd0, idt_q};
	assign age    = now_q - slot_ts_q[idx_q];

	always_comb begin
		sweep_last = 1'b1;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (i > int'(idx_q) && hit_q[i]) begin
				sweep_last = 1'b0;
			end
		end
	end

	always_comb begin
		sts.cmd        = cmd_q;
		sts.qos_nz     = |qos_q;
		sts.send_ok    = send_ok_q;
		sts.plen_zero  = (plen_q == 16'd0);
		sts.pkt_type   = hdr_q[7:4];
		sts.free_hit   = !slot_valid_q[idx_q];
		sts.match_hit  = slot_valid_q[idx_q] && (slot_id_q[idx_q] == idt_q);
		sts.expire_hit = slot_valid_q[idx_q] && (age > timeout_q);
		sts.sweep_hit  = hit_q[idx_q];
		sts.idx_last   = (idx_q == IDX_W'(SLOT_COUNT - 1));
		sts.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			cmd_q     <= command;
			qos_q     <= qos;
			send_ok_q <= send_ok;
			now_q     <= now_ticks;
			hdr_q     <= header_byte;
			rem_q     <= remaining_length;
			idt_q     <= id_or_topic_len;
			plen_q    <= packet_length;
		end
		if (cmd.wr_slot) begin
			slot_id_q[idx_q] <= res_id_q;
			slot_ts_q[idx_q] <= now_q;
		end
		if (cmd.ld_res) begin
			res_ev_q   <= cmd.res_ev;
			res_id_q   <= (cmd.res_ev == EV_ACKED) ? idt_q :
				(cmd.take_id ? next_id_q : 16'd0);
			res_tlen_q <= (cmd.res_ev == EV_DATA) ? idt_q : 16'd0;
			res_plen_q <= (cmd.res_ev == EV_DATA && !diff[17]) ? diff[7:0] : 8'd0;
			res_err_q  <= (cmd.res_ev == EV_DATA) && diff[17];
		end
		if (cmd.ld_res) begin
			res_trk_q <= 1'b0;
		end else if (cmd.wr_slot) begin
			res_trk_q <= 1'b1;
		end
		if (cmd.ld_out) begin
			out_ev_q   <= cmd.out_sweep ? EV_TIMEOUT : res_ev_q;
			out_id_q   <= cmd.out_sweep ? slot_id_q[idx_q] : res_id_q;
			out_tlen_q <= cmd.out_sweep ? 16'd0 : res_tlen_q;
			out_plen_q <= cmd.out_sweep ? 8'd0 : res_plen_q;
			out_err_q  <= cmd.out_sweep ? 1'b0 : res_err_q;
			out_trk_q  <= cmd.out_sweep ? 1'b0 : res_trk_q;
			out_conn_q <= conn_q;
			out_last_q <= cmd.out_sweep ? sweep_last : 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= TIMEOUT_RESET;
			next_id_q    <= 16'd1;
			conn_q       <= 1'b0;
			slot_valid_q <= '0;
			hit_q        <= '0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
			if (cmd.take_id) begin
				next_id_q <= (id_inc == 16'd0) ? 16'd1 : id_inc;
			end
			if (cmd.clr_table) begin
				conn_q       <= 1'b0;
				slot_valid_q <= '0;
			end else begin
				if (cmd.set_conn) begin
					conn_q <= 1'b1;
				end
				if (cmd.wr_slot) begin
					slot_valid_q[idx_q] <= 1'b1;
				end
				if (cmd.free_slot) begin
					slot_valid_q[idx_q] <= 1'b0;
				end
			end
			if (cmd.clr_hit) begin
				hit_q <= '0;
			end else if (cmd.mark_hit) begin
				hit_q[idx_q] <= 1'b1;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign event_res      = out_ev_q;
	assign msg_id         = out_id_q;
	assign topic_length   = out_tlen_q;
	assign payload_length = out_plen_q;
	assign length_error   = out_err_q;
	assign tracked        = out_trk_q;
	assign is_connected   = out_conn_q;
	assign last           = out_last_q;

endmodule

FILE: rtl/core/mat_ctrl.sv
module mat_ctrl
	import mat_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  mat_sts_t sts,
	output mat_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FREE,
		ST_MATCH,
		ST_EXPIRE,
		ST_SWEEP,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.res_ev = EV_ID_ASSIGNED;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_d   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.idx_clr = 1'b1;
				cmd.clr_hit = 1'b1;
				state_d     = ST_IDLE;
				unique case (sts.cmd)
					CMD_PUBLISH: begin
						cmd.take_id = sts.qos_nz;
						cmd.ld_res  = 1'b1;
						cmd.res_ev  = EV_ID_ASSIGNED;
						state_d     = (sts.qos_nz && sts.send_ok) ? ST_FREE : ST_EMIT;
					end
					CMD_SUBSCRIBE: begin
						cmd.take_id = 1'b1;
						cmd.ld_res  = 1'b1;
						cmd.res_ev  = EV_ID_ASSIGNED;
						state_d     = ST_EMIT;
					end
					CMD_INCOMING: begin
						priority if (sts.plen_zero) begin
							state_d = ST_IDLE;
						end else if (sts.pkt_type == PKT_CONNACK) begin
							cmd.set_conn = 1'b1;
							cmd.ld_res   = 1'b1;
							cmd.res_ev   = EV_CONNECTED;
							state_d      = ST_EMIT;
						end else if (sts.pkt_type == PKT_PUBACK) begin
							state_d = ST_MATCH;
						end else if (sts.pkt_type == PKT_SUBACK) begin
							cmd.ld_res = 1'b1;
							cmd.res_ev = EV_SUBACK;
							state_d    = ST_EMIT;
						end else if (sts.pkt_type == PKT_PUBLISH) begin
							cmd.ld_res = 1'b1;
							cmd.res_ev = EV_DATA;
							state_d    = ST_EMIT;
						end else begin
							state_d = ST_IDLE;
						end
					end
					CMD_MAINTAIN: begin
						state_d = ST_EXPIRE;
					end
					CMD_RESET: begin
						cmd.clr_table = 1'b1;
						cmd.ld_res    = 1'b1;
						cmd.res_ev    = EV_DISCONNECT;
						state_d       = ST_EMIT;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_FREE: begin
				priority if (sts.free_hit) begin
					cmd.wr_slot = 1'b1;
					state_d     = ST_EMIT;
				end else if (sts.idx_last) begin
					state_d = ST_EMIT;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_MATCH: begin
				priority if (sts.match_hit) begin
					cmd.free_slot = 1'b1;
					cmd.ld_res    = 1'b1;
					cmd.res_ev    = EV_ACKED;
					state_d       = ST_EMIT;
				end else if (sts.idx_last) begin
					state_d = ST_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_EXPIRE: begin
				cmd.free_slot = sts.expire_hit;
				cmd.mark_hit  = sts.expire_hit;
				if (sts.idx_last) begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_SWEEP;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_SWEEP: begin
				if (!sts.sweep_hit || sts.out_free) begin
					cmd.ld_out    = sts.sweep_hit;
					cmd.out_sweep = 1'b1;
					cmd.idx_inc   = !sts.idx_last;
					if (sts.idx_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/core/mqtt_ack_tracker.sv
// Packet identifier and acknowledgement tracker. One command word is taken
// at a time; the next is accepted once the current one has finished its
// work, while its last result may still sit in the output register. Publish
// with a nonzero QoS and send_ok searches the table for a free slot, a
// PUBACK searches it for the matching identifier, and a maintain command
// makes one pass that expires old entries and a second that reports them,
// all through the single slot-table port that the controller steps one slot
// per cycle, save while the sweep waits on a stalled output register. The
// timeout register may be written at any time the block is idle and takes
// effect for the next command.
module mqtt_ack_tracker
	import mat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [1:0]  qos,
	input  logic        send_ok,
	input  logic [31:0] now_ticks,
	input  logic [7:0]  header_byte,
	input  logic [7:0]  remaining_length,
	input  logic [15:0] id_or_topic_len,
	input  logic [15:0] packet_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [15:0] msg_id,
	output logic [15:0] topic_length,
	output logic [7:0]  payload_length,
	output logic        length_error,
	output logic        tracked,
	output logic        is_connected,
	output logic        last
);

	mat_cmd_t cmd;
	mat_sts_t sts;

	assign cfg_ready = 1'b1;

	mat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mat_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_valid        (cfg_valid),
		.cfg_data         (cfg_data),
		.command          (command),
		.qos              (qos),
		.send_ok          (send_ok),
		.now_ticks        (now_ticks),
		.header_byte      (header_byte),
		.remaining_length (remaining_length),
		.id_or_topic_len  (id_or_topic_len),
		.packet_length    (packet_length),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.event_res        (event_res),
		.msg_id           (msg_id),
		.topic_length     (topic_length),
		.payload_length   (payload_length),
		.length_error     (length_error),
		.tracked          (tracked),
		.is_connected     (is_connected),
		.last             (last)
	);

endmodule

FILE: rtl/core/mat_checker.sv
module mat_checker
	import mat_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  event_res,
	input logic [15:0] msg_id,
	input logic [15:0] topic_length,
	input logic [7:0]  payload_length,
	input logic        length_error,
	input logic        tracked
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(msg_id))
		else $error("output word changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new word accepted before decode");

	a_data_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_DATA |->
			topic_length == 16'd0 && payload_length == 8'd0 && !length_error)
		else $error("length fields set on a non-data event");

	a_tracked_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tracked |-> event_res == EV_ID_ASSIGNED && msg_id != 16'd0)
		else $error("tracked set without an assigned identifier");

	a_err_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_error |-> payload_length == 8'd0)
		else $error("payload length not saturated on error");

endmodule

bind mqtt_ack_tracker mat_checker u_mat_checker (.*);
